### rtl/ssrc_pkg.sv
// Shared types and codes for the sequence store with range count.
package ssrc_pkg;

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_COUNT  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Status codes returned with every result.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // Fixed field widths of the two channels.
    localparam int POS_BITS    = 11;
    localparam int END_BITS    = 10;
    localparam int VALUE_FIELD = 32;
    localparam int COUNT_BITS  = 11;

    typedef struct packed {
        logic [1:0]             kind;
        logic [POS_BITS-1:0]    position;
        logic [END_BITS-1:0]    position_end;
        logic [VALUE_FIELD-1:0] value;
    } item_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] match_count;
        logic [COUNT_BITS-1:0] length;
    } item_out_t;

endpackage

### rtl/ssrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ssrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/ssrc_seq.sv
// Sequencer that shifts or scans the store one entry per cycle through the RAM ports.
module ssrc_seq #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  ssrc_pkg::item_in_t          item,
    output logic                        res_valid,
    output ssrc_pkg::item_out_t         res,
    input  logic                        res_free,
    output logic                        mem_we,
    output logic [$clog2(CAPACITY)-1:0] mem_waddr,
    output logic [VALUE_BITS-1:0]       mem_wdata,
    output logic                        mem_re,
    output logic [$clog2(CAPACITY)-1:0] mem_raddr,
    input  logic [VALUE_BITS-1:0]       mem_rdata
);

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > ssrc_pkg::POS_BITS) ? CW : ssrc_pkg::POS_BITS;
    localparam int XW   = (VALUE_BITS > ssrc_pkg::VALUE_FIELD) ? VALUE_BITS
                                                               : ssrc_pkg::VALUE_FIELD;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [VALUE_BITS-1:0]         val_reg, val_next;
    logic [1:0]                    status_reg, status_next;
    logic [ssrc_pkg::COUNT_BITS-1:0] match_reg, match_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 last_reg, last_next;
    logic [AW-1:0]                 ins_pos_reg, ins_pos_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [AW-1:0]                 rd_addr_reg, rd_addr_next;

    logic [CMPW-1:0] n_ext;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] end_ext;
    logic [CMPW-1:0] ins_p_ext;
    logic [CMPW-1:0] n_m1_ext;
    logic [CMPW-1:0] pos_p1_ext;
    logic [CMPW-1:0] len_ext;
    logic [XW-1:0]   val_ext;

    // Widened views of the incoming fields and the element count.
    always_comb
    begin
        n_ext      = CMPW'(cnt_reg);
        pos_ext    = CMPW'(item.position);
        end_ext    = CMPW'(item.position_end);
        ins_p_ext  = (pos_ext > n_ext) ? n_ext : pos_ext;
        n_m1_ext   = n_ext - CMPW'(1);
        pos_p1_ext = pos_ext + CMPW'(1);
        val_ext    = XW'(item.value);
        len_ext    = CMPW'(cnt_reg);
    end

    assign item_ready = (state_reg == ST_IDLE);

    // Result beat and read port.
    always_comb
    begin
        res_valid       = (state_reg == ST_FINISH) && res_free;
        res.status      = status_reg;
        res.match_count = match_reg;
        res.length      = len_ext[ssrc_pkg::COUNT_BITS-1:0];
        mem_re          = (state_reg == ST_SCAN);
        mem_raddr       = ptr_reg;
    end

    // Sequencer and the shared move/compare unit.
    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        val_next      = val_reg;
        status_next   = status_reg;
        match_next    = match_reg;
        cnt_next      = cnt_reg;
        ptr_next      = ptr_reg;
        last_next     = last_reg;
        ins_pos_next  = ins_pos_reg;
        rd_valid_next = (state_reg == ST_SCAN);
        rd_addr_next  = ptr_reg;
        mem_we        = 1'b0;
        mem_waddr     = rd_addr_reg;
        mem_wdata     = mem_rdata;

        // Data returned by the previous read: move it one slot or compare it.
        if (rd_valid_reg)
        begin
            case (kind_reg)
                ssrc_pkg::KIND_INSERT:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg + AW'(1);
                end
                ssrc_pkg::KIND_DELETE:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = rd_addr_reg - AW'(1);
                end
                ssrc_pkg::KIND_COUNT:
                begin
                    if (mem_rdata == val_reg)
                    begin
                        match_next = match_reg + ssrc_pkg::COUNT_BITS'(1);
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    kind_next   = item.kind;
                    val_next    = val_ext[VALUE_BITS-1:0];
                    status_next = ssrc_pkg::STATUS_OK;
                    match_next  = '0;
                    state_next  = ST_FINISH;
                    case (item.kind)
                        ssrc_pkg::KIND_INSERT:
                        begin
                            if (n_ext >= CMPW'(CAPACITY))
                            begin
                                status_next = ssrc_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cnt_next     = cnt_reg + CW'(1);
                                ins_pos_next = ins_p_ext[AW-1:0];
                                ptr_next     = n_m1_ext[AW-1:0];
                                last_next    = ins_p_ext[AW-1:0];
                                if (ins_p_ext == n_ext)
                                begin
                                    state_next = ST_WRITE;
                                end
                                else
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        ssrc_pkg::KIND_DELETE:
                        begin
                            if (pos_ext >= n_ext)
                            begin
                                status_next = ssrc_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                cnt_next  = cnt_reg - CW'(1);
                                ptr_next  = pos_p1_ext[AW-1:0];
                                last_next = n_m1_ext[AW-1:0];
                                if (pos_p1_ext != n_ext)
                                begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        ssrc_pkg::KIND_COUNT:
                        begin
                            if ((end_ext >= n_ext) || (pos_ext > end_ext))
                            begin
                                status_next = ssrc_pkg::STATUS_RANGE;
                            end
                            else
                            begin
                                ptr_next   = pos_ext[AW-1:0];
                                last_next  = end_ext[AW-1:0];
                                state_next = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            status_next = ssrc_pkg::STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // One read per cycle, walking down for insert and up otherwise.
                if (ptr_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else if (kind_reg == ssrc_pkg::KIND_INSERT)
                begin
                    ptr_next = ptr_reg - AW'(1);
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (kind_reg == ssrc_pkg::KIND_INSERT)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                mem_waddr  = ins_pos_reg;
                mem_wdata  = val_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        match_reg   <= match_next;
        ptr_reg     <= ptr_next;
        last_reg    <= last_next;
        ins_pos_reg <= ins_pos_next;
        rd_addr_reg <= rd_addr_next;
    end

endmodule

### rtl/sequence_store_range_count.sv
// Top level of the sequence store with positional insert, delete and range count.
//
// The block keeps up to CAPACITY values of VALUE_BITS bits in order in one RAM and
// takes one item at a time. An insert of a value at position p (clamped to the current
// length n) shifts the elements from p upward before it writes the value; a delete at
// position p shifts the elements after p down; a count over positions s to e scans
// those elements. Rejected items and the unused kind finish without touching the RAM.
// The work is paced by the single RAM read port: every shifted or scanned element
// costs one read, with the write of the shifted element overlapping the next read.
// A result beat waits in an output register, and the block takes the next item while
// it waits.
module sequence_store_range_count #(
    parameter int CAPACITY   = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  ssrc_pkg::item_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output ssrc_pkg::item_out_t result
);

    localparam int AW = $clog2(CAPACITY);

    logic                  res_valid;
    ssrc_pkg::item_out_t   res;
    logic                  res_free;
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [VALUE_BITS-1:0] mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [VALUE_BITS-1:0] mem_rdata;

    logic                  result_valid_reg;
    ssrc_pkg::item_out_t   result_reg;

    ssrc_seq #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .res_valid  (res_valid),
        .res        (res),
        .res_free   (res_free),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    ssrc_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // The output register can take a new beat when empty or being drained.
    assign res_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Output beat valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // Output beat payload.
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            result_reg <= res;
        end
    end

endmodule
